>>> hdl/clcd_pkg.sv
// Shared types and constants for the character LCD nibble write sequencer.
// Holds the sequencer phase encoding, register indexes and the power-on command table.
// No dependencies.
package clcd_pkg;

  // Number of power-on instruction bytes sent after the first long wait.
  localparam int unsigned INIT_STEPS = 6;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned TDATA_W    = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PRE_WRITE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_HOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_WAIT = 2'd2;

  localparam logic [15:0] PRE_WRITE_RST = 16'd1000;
  localparam logic [7:0]  DATA_HOLD_RST = 8'd20;
  localparam logic [15:0] LONG_WAIT_RST = 16'd50000;

  localparam logic [15:0] POST_FUNC_SET = 16'd100;
  localparam logic [15:0] POST_SHORT    = 16'd50;

  typedef enum logic [8:0] {
    PH_PWAIT = 9'b000000001,
    PH_PRE   = 9'b000000010,
    PH_HL    = 9'b000000100,
    PH_HH    = 9'b000001000,
    PH_HG    = 9'b000010000,
    PH_LL    = 9'b000100000,
    PH_LH    = 9'b001000000,
    PH_POST  = 9'b010000000,
    PH_IDLE  = 9'b100000000
  } phase_t;

  // Power-on instruction bytes: function set three times, display on,
  // entry mode, then clear (repeated for any further steps).
  function automatic logic [7:0] init_cmd(input logic [2:0] step);
    logic [7:0] cmd;
    case (step)
      3'd0, 3'd1, 3'd2: cmd = 8'h28;
      3'd3:             cmd = 8'h0C;
      3'd4:             cmd = 8'h06;
      default:          cmd = 8'h01;
    endcase
    return cmd;
  endfunction

endpackage

>>> hdl/char_lcd_nibble_write_sequencer.sv
// Character LCD write sequencer for a 4-bit write-only bus, top level.
// Each input transfer is one microsecond tick; each tick gives one pin-state result.
// Depends on clcd_pkg.
//
// Usage:
//   in_*  : one transfer per microsecond tick. in_tdata[0] marks a byte request,
//           in_tdata[8:1] is the byte, in_tuser[0] selects data (RS high) or
//           instruction. Requests on ticks that are not ready are dropped.
//   out_* : one transfer per tick with the RS, RW, E and D4..D7 levels for that
//           tick, plus the ready and accepted flags.
//   cfg_* : register writes (0 pre-write wait, 1 data hold, 2 long wait), taken
//           at once; cfg_ready is always high. Write only while the stream is idle.
// An input transfer reaches its result through the input register, then the result
// register. One tick is taken every cycle while the receiver takes results, set by
// the single sequencer update between the two registers.
// Reset (synchronous, rst_n low) clears both registers, loads the register
// defaults and restarts the power-on sequence. When the receiver stalls, the
// result register holds and the input register still takes one more tick if it is
// empty; after that in_tready drops until the result is taken.
module char_lcd_nibble_write_sequencer #(
  parameter int unsigned INIT_STEPS = clcd_pkg::INIT_STEPS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input ticks.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [clcd_pkg::TDATA_W-1:0]        in_tdata,  // req_valid, req_byte[7:0], zero fill
  input  logic                                in_tuser,  // req_is_data
  // Pin-state results.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [clcd_pkg::TDATA_W-1:0]        out_tdata, // pin_rs, pin_rw, pin_enable,
                                                         // pin_nibble[3:0], ready_res,
                                                         // accepted, zero fill
  // Register writes.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [clcd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [clcd_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import clcd_pkg::*;

  // Configuration registers.
  logic [15:0] pre_wait_r;
  logic [7:0]  hold_r;
  logic [15:0] long_wait_r;

  // Input register.
  logic        in_v_r;
  logic        req_valid_r;
  logic        req_is_data_r;
  logic [7:0]  req_byte_r;

  // Sequencer state.
  phase_t      phase_r, phase_nxt;
  logic [15:0] wait_r, wait_nxt;
  logic [7:0]  held_byte_r, held_byte_nxt;
  logic        held_is_data_r, held_is_data_nxt;
  logic [2:0]  step_r, step_nxt;
  logic        init_done_r, init_done_nxt;
  logic        pin_rs_r, pin_rs_nxt;
  logic [3:0]  pin_nib_r, pin_nib_nxt;

  // Result register.
  logic                 out_v_r;
  logic [TDATA_W-1:0]   out_data_r, out_data_nxt;

  logic        advance;
  logic        pin_e;
  logic        rdy;
  logic        acc;

  // Intermediate terms of the tick update.
  logic [15:0] post_tgt;
  logic        pwait_done;
  logic        post_done;
  logic        post_last;
  logic        load;
  logic [2:0]  step_eff;
  logic [7:0]  byte_eff;
  logic        is_data_eff;
  logic [15:0] wait_eff;
  logic [15:0] wait_inc;
  logic [15:0] hold_tgt;
  phase_t      phase_eff;

  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    if (step_r < 3'd3) begin
      post_tgt = POST_FUNC_SET;
    end else if (step_r < 3'd5) begin
      post_tgt = POST_SHORT;
    end else begin
      post_tgt = long_wait_r;
    end

    pwait_done = (phase_r == PH_PWAIT) && (wait_r >= long_wait_r);
    post_done  = (phase_r == PH_POST) && (wait_r >= post_tgt);
    post_last  = post_done &&
                 (({1'b0, step_r} + 4'd1) >= INIT_STEPS[3:0]);
    load       = pwait_done || (post_done && !post_last);
    step_eff   = (post_done && !post_last) ? (step_r + 3'd1) : step_r;
    byte_eff    = load ? init_cmd(step_eff) : held_byte_r;
    is_data_eff = load ? 1'b0 : held_is_data_r;
    wait_eff    = (load || post_last) ? 16'd0 : wait_r;
    wait_inc    = wait_eff + 16'd1;
    hold_tgt    = (is_data_eff && (hold_r > 8'd1)) ? {8'd0, hold_r} : 16'd1;

    // A finished wait falls straight into the step after it within the same tick.
    if (load) begin
      phase_eff = (pre_wait_r == 16'd0) ? PH_HL : PH_PRE;
    end else if ((phase_r == PH_PRE) && (wait_r >= pre_wait_r)) begin
      phase_eff = PH_HL;
    end else if (post_last) begin
      phase_eff = PH_IDLE;
    end else begin
      phase_eff = phase_r;
    end

    phase_nxt        = phase_eff;
    wait_nxt         = wait_eff;
    held_byte_nxt    = byte_eff;
    held_is_data_nxt = is_data_eff;
    step_nxt         = step_eff;
    init_done_nxt    = init_done_r || post_last;
    pin_rs_nxt       = pin_rs_r;
    pin_nib_nxt      = pin_nib_r;
    pin_e            = 1'b0;
    rdy              = 1'b0;
    acc              = 1'b0;

    case (phase_eff)
      PH_PWAIT, PH_PRE, PH_POST: begin
        wait_nxt = wait_inc;
      end
      PH_HL: begin
        pin_nib_nxt = byte_eff[7:4];
        pin_rs_nxt  = is_data_eff;
        phase_nxt   = PH_HH;
      end
      PH_HH: begin
        pin_e     = 1'b1;
        phase_nxt = PH_HG;
      end
      PH_HG: begin
        phase_nxt = PH_LL;
      end
      PH_LL: begin
        pin_nib_nxt = byte_eff[3:0];
        phase_nxt   = PH_LH;
        wait_nxt    = 16'd0;
      end
      PH_LH: begin
        pin_e = 1'b1;
        if (wait_inc >= hold_tgt) begin
          wait_nxt  = 16'd0;
          phase_nxt = init_done_r ? PH_IDLE : PH_POST;
        end else begin
          wait_nxt = wait_inc;
        end
      end
      default: begin
        rdy = 1'b1;
        if (req_valid_r) begin
          acc              = 1'b1;
          held_byte_nxt    = req_byte_r;
          held_is_data_nxt = req_is_data_r;
          phase_nxt        = PH_PRE;
          wait_nxt         = 16'd0;
        end
      end
    endcase

    out_data_nxt = {{(TDATA_W-9){1'b0}}, acc, rdy, pin_nib_nxt, pin_e, 1'b0, pin_rs_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_wait_r  <= PRE_WRITE_RST;
      hold_r      <= DATA_HOLD_RST;
      long_wait_r <= LONG_WAIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PRE_WRITE: pre_wait_r  <= cfg_data;
        CFG_DATA_HOLD: hold_r      <= cfg_data[7:0];
        CFG_LONG_WAIT: long_wait_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register takes a tick whenever it is empty or drains this cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      req_valid_r   <= in_tdata[0];
      req_byte_r    <= in_tdata[8:1];
      req_is_data_r <= in_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_PWAIT;
      wait_r         <= 16'd0;
      held_byte_r    <= 8'd0;
      held_is_data_r <= 1'b0;
      step_r         <= 3'd0;
      init_done_r    <= 1'b0;
      pin_rs_r       <= 1'b0;
      pin_nib_r      <= 4'd0;
    end else if (advance) begin
      phase_r        <= phase_nxt;
      wait_r         <= wait_nxt;
      held_byte_r    <= held_byte_nxt;
      held_is_data_r <= held_is_data_nxt;
      step_r         <= step_nxt;
      init_done_r    <= init_done_nxt;
      pin_rs_r       <= pin_rs_nxt;
      pin_nib_r      <= pin_nib_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  // The idle phase is reachable only once the power-on sequence has finished.
  a_idle_after_init: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> init_done_r)
    else $error("idle phase reached before power-on sequence finished");

  // With both registers full and the receiver stalled, no tick may be taken.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && out_v_r && !out_tready) |-> !in_tready)
    else $error("input taken while both stages are blocked");

  // A taken request starts the pre-write wait on the following tick.
  a_accept_starts_write: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && acc) |=> (phase_r == PH_PRE))
    else $error("accepted request did not start the pre-write wait");

  // The strobe is never high on a tick that reports ready.
  a_no_strobe_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && rdy) |=> !out_data_r[2])
    else $error("enable high on an idle tick");

endmodule

>>> verif/clcd_pin_checker.sv
// Pin-level checker for the character LCD nibble write sequencer.
// Watches the tick, result and register-write channels, keeps its own copy of the
// sequencer and compares each result transfer field by field. Depends on clcd_pkg.
module clcd_pin_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [clcd_pkg::TDATA_W-1:0]   in_tdata,   // req_valid, req_byte[7:0], zero fill
  input  logic                           in_tuser,   // req_is_data
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [clcd_pkg::TDATA_W-1:0]   out_tdata,  // pin_rs, pin_rw, pin_enable,
                                                     // pin_nibble[3:0], ready_res,
                                                     // accepted, zero fill
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [clcd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [clcd_pkg::CFG_DATA_W-1:0] cfg_data,
  output int unsigned                    mismatches,
  output int unsigned                    pins_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import clcd_pkg::*;

  // Power-on bytes, step 0 in the lowest byte; steps past the clear repeat it.
  localparam logic [63:0] POWER_ON_BYTES = 64'h0101_0106_0C28_2828;

  typedef struct packed {
    logic       rs;
    logic       rw;
    logic       en;
    logic [3:0] nib;
    logic       rdy;
    logic       acc;
  } pin_state_t;

  // Register copies.
  logic [15:0] pre_us;
  logic [7:0]  hold_us;
  logic [15:0] long_us;

  // Sequencer copy.
  phase_t      phase;
  logic [15:0] wait_cnt;
  logic [7:0]  byte_q;
  logic        is_data_q;
  logic [2:0]  step;
  logic        power_on_done;
  logic        rs_q;
  logic        en_q;
  logic [3:0]  nib_q;

  pin_state_t  pins_due[$];

  task automatic fetch_power_on_byte();
    byte_q    = POWER_ON_BYTES[step*8 +: 8];
    is_data_q = 1'b0;
    phase     = PH_PRE;
    wait_cnt  = '0;
  endtask

  // One microsecond tick: runs the zero-time phase changes until a phase
  // consumes the tick, then reports the pin levels held during it.
  task automatic advance_tick(input logic req_v, input logic req_d, input logic [7:0] req_b,
                              output pin_state_t res);
    logic        settled;
    logic [15:0] target;
    res     = '0;
    settled = 1'b0;
    while (!settled) begin
      case (phase)
        PH_PWAIT: begin
          if (wait_cnt >= long_us) begin
            fetch_power_on_byte();
          end else begin
            en_q = 1'b0;
            wait_cnt++;
            settled = 1'b1;
          end
        end
        PH_PRE: begin
          if (wait_cnt >= pre_us) begin
            phase = PH_HL;
          end else begin
            en_q = 1'b0;
            wait_cnt++;
            settled = 1'b1;
          end
        end
        PH_HL: begin
          nib_q = byte_q[7:4];
          rs_q  = is_data_q;
          en_q  = 1'b0;
          phase = PH_HH;
          settled = 1'b1;
        end
        PH_HH: begin
          en_q  = 1'b1;
          phase = PH_HG;
          settled = 1'b1;
        end
        PH_HG: begin
          en_q  = 1'b0;
          phase = PH_LL;
          settled = 1'b1;
        end
        PH_LL: begin
          nib_q    = byte_q[3:0];
          en_q     = 1'b0;
          phase    = PH_LH;
          wait_cnt = '0;
          settled  = 1'b1;
        end
        PH_LH: begin
          // A hold of zero behaves like one; only data writes use the hold time.
          target = (is_data_q && hold_us > 8'd1) ? 16'(hold_us) : 16'd1;
          en_q = 1'b1;
          wait_cnt++;
          if (wait_cnt >= target) begin
            wait_cnt = '0;
            phase    = power_on_done ? PH_IDLE : PH_POST;
          end
          settled = 1'b1;
        end
        PH_POST: begin
          target = (step < 3'd3) ? POST_FUNC_SET : (step < 3'd5) ? POST_SHORT : long_us;
          if (wait_cnt >= target) begin
            if (int'(step) + 1 >= INIT_STEPS) begin
              power_on_done = 1'b1;
              phase         = PH_IDLE;
              wait_cnt      = '0;
            end else begin
              step = step + 3'd1;
              fetch_power_on_byte();
            end
          end else begin
            en_q = 1'b0;
            wait_cnt++;
            settled = 1'b1;
          end
        end
        default: begin
          en_q    = 1'b0;
          res.rdy = 1'b1;
          if (req_v) begin
            res.acc   = 1'b1;
            byte_q    = req_b;
            is_data_q = req_d;
            phase     = PH_PRE;
            wait_cnt  = '0;
          end
          settled = 1'b1;
        end
      endcase
    end
    res.rs  = rs_q;
    res.rw  = 1'b0;
    res.en  = en_q;
    res.nib = nib_q;
  endtask

  task automatic compare_field(input string field, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    pin_state_t want;
    pin_state_t got;
    if (!rst_n) begin
      pre_us        = PRE_WRITE_RST;
      hold_us       = DATA_HOLD_RST;
      long_us       = LONG_WAIT_RST;
      phase         = PH_PWAIT;
      wait_cnt      = '0;
      byte_q        = '0;
      is_data_q     = 1'b0;
      step          = '0;
      power_on_done = 1'b0;
      rs_q          = 1'b0;
      en_q          = 1'b0;
      nib_q         = '0;
      pins_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PRE_WRITE: pre_us  = cfg_data;
          CFG_DATA_HOLD: hold_us = cfg_data[7:0];
          CFG_LONG_WAIT: long_us = cfg_data;
          default: ;
        endcase
      end
      // The result leaving now belongs to an older tick, so compare before predicting.
      if (out_tvalid && out_tready) begin
        got.rs  = out_tdata[0];
        got.rw  = out_tdata[1];
        got.en  = out_tdata[2];
        got.nib = out_tdata[6:3];
        got.rdy = out_tdata[7];
        got.acc = out_tdata[8];
        if (pins_due.size() == 0) begin
          mismatches++;
          $display("%0t: result transfer with no tick pending, expected none got %h",
                   $time, out_tdata);
        end else begin
          want = pins_due.pop_front();
          compare_field("pin_rs", 32'(want.rs), 32'(got.rs));
          compare_field("pin_rw", 32'(want.rw), 32'(got.rw));
          compare_field("pin_enable", 32'(want.en), 32'(got.en));
          compare_field("pin_nibble", 32'(want.nib), 32'(got.nib));
          compare_field("ready_res", 32'(want.rdy), 32'(got.rdy));
          compare_field("accepted", 32'(want.acc), 32'(got.acc));
        end
      end
      if (in_tvalid && in_tready) begin
        advance_tick(in_tdata[0], in_tuser, in_tdata[8:1], want);
        pins_due.push_back(want);
      end
    end
    pins_pending = pins_due.size();
  end

endmodule

>>> verif/tb.sv
// Testbench top for the character LCD nibble write sequencer.
// Drives microsecond ticks and register writes, idles both sides at random and
// gives the verdict from clcd_pin_checker. Depends on clcd_pkg and the RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import clcd_pkg::*;

  localparam int unsigned GAP_MAX          = 6;
  localparam int unsigned SETTLE_CYCLES    = 8;
  localparam int unsigned TICKS_TARGET     = 1550;
  localparam int unsigned PRESSURE_CYCLES  = 80;
  localparam int unsigned OUT_ACCEPTED_BIT = 8;
  localparam int unsigned CYCLE_LIMIT      = 200_000;
  // Index beyond the three registers; a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [TDATA_W-1:0]    in_tdata  = '0;
  logic                  in_tuser  = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [TDATA_W-1:0]    out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int unsigned mismatches;
  int unsigned pins_pending;
  int unsigned cycle_cnt    = 0;
  int unsigned ticks_in     = 0;
  int unsigned ticks_out    = 0;
  int unsigned accepts_seen = 0;
  bit          gaps_on      = 1'b0;
  bit          press_req    = 1'b0;
  bit          press_done   = 1'b0;

  always #5 clk = ~clk;

  char_lcd_nibble_write_sequencer #(
    .INIT_STEPS (INIT_STEPS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  clcd_pin_checker pin_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .pins_pending (pins_pending)
  );

  always @(posedge clk) begin
    if (in_tvalid && in_tready) ticks_in <= ticks_in + 1;
    if (out_tvalid && out_tready) begin
      ticks_out <= ticks_out + 1;
      if (out_tdata[OUT_ACCEPTED_BIT]) accepts_seen <= accepts_seen + 1;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Result side: a random stall before each transfer, and once a long hold-off
  // so that the block fills up and drops in_tready.
  initial begin : result_sink
    int unsigned stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = gaps_on ? $urandom_range(0, GAP_MAX) : 0;
      if (press_req && !press_done) begin
        stall      = PRESSURE_CYCLES;
        press_done = 1'b1;
      end
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_tick(input logic req_v, input logic req_d, input logic [7:0] req_b);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, GAP_MAX) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= TDATA_W'({req_b, req_v});
    in_tuser  <= req_d;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic run_ticks(input int unsigned count);
    repeat (count) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             8'($urandom_range(0, 255)));
  endtask

  // Keeps offering one byte write until a result reports it taken. Ticks that
  // arrive while the block is busy are dropped by it, which is part of the test.
  task automatic offer_write(input logic req_d, input logic [7:0] req_b);
    int unsigned seen;
    seen = accepts_seen;
    while (accepts_seen == seen) begin
      if ($urandom_range(0, 7) == 0)
        send_tick(1'b0, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      else
        send_tick(1'b1, req_d, req_b);
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (ticks_out != ticks_in) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned batch;
    int unsigned pre_val;
    int unsigned hold_val;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Power-on wait at the reset values; every request is dropped here.
    gaps_on = 1'b1;
    run_ticks(30);
    write_reg(CFG_LONG_WAIT, 16'hFFFF);
    run_ticks(10);
    // A long wait below the ticks already waited ends at once; the wait after
    // the clear command then uses it as well.
    write_reg(CFG_LONG_WAIT, 16'd7);
    run_ticks(20);
    // The first pre-write wait is cut short the same way.
    write_reg(CFG_PRE_WRITE, 16'd3);

    // The receiver holds off once while the sender keeps offering ticks.
    press_req = 1'b1;

    // Byte extremes with the default data hold; offers during the rest of the
    // power-on sequence are dropped.
    offer_write(1'b1, 8'h00);
    offer_write(1'b1, 8'hFF);
    offer_write(1'b0, 8'h00);
    offer_write(1'b0, 8'hFF);
    write_reg(CFG_DATA_HOLD, 16'd0);
    offer_write(1'b1, 8'hC3);
    // Only the low byte of the data hold register is kept.
    write_reg(CFG_DATA_HOLD, 16'hA502);
    offer_write(1'b1, 8'h3C);
    write_reg(CFG_DATA_HOLD, 16'd1);
    offer_write(1'b1, 8'h96);
    offer_write(1'b0, 8'h69);
    write_reg(CFG_DATA_HOLD, 16'd255);
    offer_write(1'b1, 8'h81);
    write_reg(CFG_DATA_HOLD, 16'd4);
    write_reg(CFG_PRE_WRITE, 16'd0);
    offer_write(1'b0, 8'h7E);
    offer_write(1'b1, 8'h18);
    write_reg(CFG_NO_REG, 16'hFFFF);
    offer_write(1'b1, 8'hE7);

    // Longest pre-write wait, cut short by a smaller value partway through.
    gaps_on = 1'b0;
    write_reg(CFG_PRE_WRITE, 16'hFFFF);
    offer_write(1'b1, 8'h42);
    run_ticks(40);
    write_reg(CFG_PRE_WRITE, 16'd20);
    run_ticks(30);
    gaps_on = 1'b1;

    while (ticks_in < TICKS_TARGET) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      pre_val = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      write_reg(CFG_PRE_WRITE, 16'(pre_val));
      hold_val = $urandom_range(0, 6);
      batch    = $urandom_range(3, 8);
      write_reg(CFG_DATA_HOLD, 16'(hold_val));
      // The long wait no longer matters once the power-on sequence is over.
      if ($urandom_range(0, 4) == 0) write_reg(CFG_LONG_WAIT, 16'($urandom_range(0, 65535)));
      repeat (batch) begin
        offer_write(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) == 0) run_ticks($urandom_range(1, 4));
      end
    end

    settle();
    if (mismatches == 0 && pins_pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
